[src/calendar_clock_with_alarm_core_macros.svh]
// ----------------------------------------------------------------------------
// Calendar clock assertion macros
// Shared concurrent assertion forms for the calendar clock checker.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_WITH_ALARM_CORE_MACROS_SVH
`define CALENDAR_CLOCK_WITH_ALARM_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCWA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calendar clock assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calendar clock assertion failed");

`endif

[src/ccwa_pkg.sv]
// ----------------------------------------------------------------------------
// Calendar clock package
// Field widths, limits and reset values shared by the core and its checker.
// ----------------------------------------------------------------------------
package ccwa_pkg;

  localparam int unsigned ModeW  = 4;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned StepsW = 10;
  localparam int unsigned YearPartW = 7;

  localparam logic [SecW-1:0]   SecLast    = SecW'(59);
  localparam logic [MinW-1:0]   MinLast    = MinW'(59);
  localparam logic [HourW-1:0]  HourLast   = HourW'(23);
  localparam logic [HourW-1:0]  HourLimit24 = HourW'(24);
  localparam logic [HourW-1:0]  HourLimit12 = HourW'(12);
  localparam logic [DayW-1:0]   DayFirst   = DayW'(1);
  localparam logic [DayW-1:0]   DayLast31  = DayW'(31);
  localparam logic [DayW-1:0]   DayLast30  = DayW'(30);
  localparam logic [DayW-1:0]   DayLastLeap = DayW'(29);
  localparam logic [DayW-1:0]   DayLastFeb = DayW'(28);
  localparam logic [MonthW-1:0] MonthJan   = MonthW'(1);
  localparam logic [MonthW-1:0] MonthFeb   = MonthW'(2);
  localparam logic [MonthW-1:0] MonthApr   = MonthW'(4);
  localparam logic [MonthW-1:0] MonthJun   = MonthW'(6);
  localparam logic [MonthW-1:0] MonthSep   = MonthW'(9);
  localparam logic [MonthW-1:0] MonthNov   = MonthW'(11);
  localparam logic [MonthW-1:0] MonthDec   = MonthW'(12);
  localparam logic [YearW-1:0]  YearLast   = YearW'(9999);
  localparam logic [YearPartW-1:0] YearPartLast = YearPartW'(99);
  localparam logic [ModeW-1:0]  ModeLast   = ModeW'(11);

  localparam logic [YearW-1:0]     YearReset    = YearW'(2023);
  localparam logic [YearPartW-1:0] CenturyReset = YearPartW'(20);
  localparam logic [YearPartW-1:0] YearLoReset  = YearPartW'(23);
  localparam logic [StepsW-1:0]    StepsReset   = StepsW'(500);

  localparam int unsigned SecCount  = 60;
  localparam int unsigned MinCount  = 60;
  localparam int unsigned HourCount = 24;

endpackage

[src/calendar_clock_with_alarm_core.sv]
// Latency: a result beat is offered the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless the output stalls, one update per beat.
// Input is stalled only while a finished result beat is held by a stalled output.
// Reset: asynchronous, active low; time 00:00:00, January 1 2023, alarm 00:00:00,
// 24-hour limit, date view length 500 steps, mode init, no result pending.
// ----------------------------------------------------------------------------
// Calendar clock with alarm core
// Time and Gregorian calendar counters, alarm compare and a twelve-state
// user-interface mode machine, updated once per accepted input beat.
// ----------------------------------------------------------------------------
module calendar_clock_with_alarm_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            date_view_steps_we_i,
  input  logic [ccwa_pkg::StepsW-1:0]     date_view_steps_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            second_tick_i,
  input  logic                            button_mode_i,
  input  logic                            button_select_i,
  input  logic                            button_adjust_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ccwa_pkg::ModeW-1:0]      mode_state_o,
  output logic [ccwa_pkg::HourW-1:0]      hours_o,
  output logic [ccwa_pkg::MinW-1:0]       minutes_o,
  output logic [ccwa_pkg::SecW-1:0]       seconds_o,
  output logic [ccwa_pkg::DayW-1:0]       day_of_month_o,
  output logic [ccwa_pkg::MonthW-1:0]     month_number_o,
  output logic [ccwa_pkg::YearW-1:0]      year_number_o,
  output logic [ccwa_pkg::HourW-1:0]      alarm_hours_o,
  output logic [ccwa_pkg::MinW-1:0]       alarm_minutes_o,
  output logic [ccwa_pkg::SecW-1:0]       alarm_seconds_o,
  output logic                            alarm_active_o,
  output logic                            twelve_hour_limit_o
);
  import ccwa_pkg::*;

  typedef enum logic [ModeW-1:0] {
    ModeInit,
    ModeTime,
    ModeTimedDate,
    ModeDate,
    ModeHourFmt,
    ModeAlarmView,
    ModeAlarmHour,
    ModeAlarmMin,
    ModeAlarmSec,
    ModeZone,
    ModeInc,
    ModeDec
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [SecW-1:0]      sec_q, sec_d, sec_adv;
  logic [MinW-1:0]      min_q, min_d, min_adv;
  logic [HourW-1:0]     hour_q, hour_d, hour_adv;
  logic [DayW-1:0]      day_q, day_d;
  logic [MonthW-1:0]    month_q, month_d;
  logic [YearW-1:0]     year_q, year_d;
  logic [YearPartW-1:0] year_lo_q, year_lo_d;
  logic [YearPartW-1:0] century_q, century_d;
  logic [HourW-1:0]     alarm_hour_q, alarm_hour_d;
  logic [MinW-1:0]      alarm_min_q, alarm_min_d;
  logic [SecW-1:0]      alarm_sec_q, alarm_sec_d;
  logic                 twelve_q, twelve_d;
  logic [StepsW-1:0]    view_cnt_q, view_cnt_d, view_cnt_inc;
  logic [StepsW-1:0]    steps_q;
  logic                 alarm_q, alarm_d;
  logic                 out_valid_q;
  logic                 in_accept;
  logic                 leap_year;
  logic                 short_month;
  logic                 month_end;
  logic [DayW-1:0]      feb_last;

  function automatic logic [HourW-1:0] hour_up(logic [HourW-1:0] h, logic twelve);
    logic [HourW-1:0] nxt;
    logic [HourW-1:0] limit;
    limit = twelve ? HourLimit12 : HourLimit24;
    nxt   = h + 1'b1;
    return (nxt >= limit) ? '0 : nxt;
  endfunction

  function automatic logic [HourW-1:0] hour_down(logic [HourW-1:0] h, logic twelve);
    logic [HourW-1:0] limit;
    limit = twelve ? HourLimit12 : HourLimit24;
    return (h == '0) ? (limit - 1'b1) : (h - 1'b1);
  endfunction

  assign in_stall_o   = out_valid_q & out_stall_i;
  assign in_accept    = in_valid_i & ~in_stall_o;
  assign view_cnt_inc = view_cnt_q + 1'b1;

  // The year is tracked as century and year within century to find leap years.
  assign leap_year   = (year_lo_q[1:0] == 2'b00) &&
                       ((year_lo_q != '0) || (century_q[1:0] == 2'b00));
  assign feb_last    = leap_year ? DayLastLeap : DayLastFeb;
  assign short_month = (month_q == MonthApr) || (month_q == MonthJun) ||
                       (month_q == MonthSep) || (month_q == MonthNov);
  assign month_end   = (day_q == DayLast31) || (short_month && (day_q == DayLast30)) ||
                       ((month_q == MonthFeb) && (day_q == feb_last));

  always_comb begin
    sec_adv   = sec_q;
    min_adv   = min_q;
    hour_adv  = hour_q;
    day_d     = day_q;
    month_d   = month_q;
    year_d    = year_q;
    year_lo_d = year_lo_q;
    century_d = century_q;
    alarm_d   = alarm_q;
    if (second_tick_i) begin
      if (sec_q == SecLast) begin
        sec_adv = '0;
        if (min_q == MinLast) begin
          min_adv = '0;
          if (hour_q == HourLast) begin
            hour_adv = '0;
            if (month_end) begin
              day_d = DayFirst;
              if (month_q == MonthDec) begin
                month_d = MonthJan;
                year_d  = (year_q >= YearLast) ? '0 : year_q + 1'b1;
                if (year_lo_q == YearPartLast) begin
                  year_lo_d = '0;
                  century_d = (century_q == YearPartLast) ? '0 : century_q + 1'b1;
                end else begin
                  year_lo_d = year_lo_q + 1'b1;
                end
              end else begin
                month_d = month_q + 1'b1;
              end
            end else begin
              day_d = day_q + 1'b1;
            end
          end else begin
            hour_adv = hour_q + 1'b1;
          end
        end else begin
          min_adv = min_q + 1'b1;
        end
      end else begin
        sec_adv = sec_q + 1'b1;
      end
      if ((hour_adv == alarm_hour_q) && (min_adv == alarm_min_q) &&
          (sec_adv == alarm_sec_q)) begin
        alarm_d = 1'b1;
      end
    end
    if (button_adjust_i) begin
      alarm_d = 1'b0;
    end
  end

  always_comb begin
    mode_d       = mode_q;
    sec_d        = sec_adv;
    min_d        = min_adv;
    hour_d       = hour_adv;
    alarm_hour_d = alarm_hour_q;
    alarm_min_d  = alarm_min_q;
    alarm_sec_d  = alarm_sec_q;
    twelve_d     = twelve_q;
    view_cnt_d   = view_cnt_q;
    case (mode_q)
      ModeInit: begin
        mode_d = ModeTime;
      end
      ModeTime: begin
        if (button_mode_i) mode_d = ModeDate;
        if (button_select_i) mode_d = ModeTimedDate;
      end
      ModeTimedDate: begin
        if (button_mode_i) mode_d = ModeDate;
        if (view_cnt_inc >= steps_q) begin
          view_cnt_d = '0;
          mode_d     = ModeTime;
        end else begin
          view_cnt_d = view_cnt_inc;
        end
      end
      ModeDate: begin
        if (button_mode_i) mode_d = ModeHourFmt;
      end
      ModeHourFmt: begin
        if (button_mode_i) mode_d = ModeAlarmView;
        if (button_select_i) twelve_d = 1'b0;
        if (button_adjust_i) twelve_d = 1'b1;
      end
      ModeAlarmView: begin
        if (button_mode_i) mode_d = ModeZone;
        if (button_select_i) mode_d = ModeAlarmHour;
      end
      ModeAlarmHour: begin
        if (button_select_i) mode_d = ModeAlarmMin;
        if (button_adjust_i) alarm_hour_d = hour_up(alarm_hour_q, twelve_q);
        if (button_mode_i) mode_d = ModeZone;
      end
      ModeAlarmMin: begin
        if (button_select_i) mode_d = ModeAlarmSec;
        if (button_adjust_i) begin
          alarm_min_d = (alarm_min_q == MinLast) ? '0 : alarm_min_q + 1'b1;
        end
        if (button_mode_i) mode_d = ModeZone;
      end
      ModeAlarmSec: begin
        if (button_select_i) mode_d = ModeAlarmHour;
        if (button_adjust_i) begin
          alarm_sec_d = (alarm_sec_q == SecLast) ? '0 : alarm_sec_q + 1'b1;
        end
        if (button_mode_i) mode_d = ModeZone;
      end
      ModeZone: begin
        if (button_mode_i) mode_d = ModeTime;
        if (button_select_i) mode_d = ModeInc;
      end
      ModeInc: begin
        if (button_mode_i) mode_d = ModeTime;
        if (button_select_i) hour_d = hour_up(hour_d, twelve_q);
        if (button_adjust_i) begin
          mode_d = ModeDec;
          hour_d = hour_down(hour_d, twelve_q);
        end
      end
      ModeDec: begin
        if (button_mode_i) mode_d = ModeTime;
        if (button_select_i) begin
          mode_d = ModeInc;
          hour_d = hour_up(hour_d, twelve_q);
        end
        if (button_adjust_i) hour_d = hour_down(hour_d, twelve_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeInit;
      sec_q        <= '0;
      min_q        <= '0;
      hour_q       <= '0;
      day_q        <= DayFirst;
      month_q      <= MonthJan;
      year_q       <= YearReset;
      year_lo_q    <= YearLoReset;
      century_q    <= CenturyReset;
      alarm_hour_q <= '0;
      alarm_min_q  <= '0;
      alarm_sec_q  <= '0;
      twelve_q     <= 1'b0;
      view_cnt_q   <= '0;
      alarm_q      <= 1'b0;
      steps_q      <= StepsReset;
      out_valid_q  <= 1'b0;
    end else begin
      if (date_view_steps_we_i) begin
        steps_q <= date_view_steps_i;
      end
      if (in_accept) begin
        mode_q       <= mode_d;
        sec_q        <= sec_d;
        min_q        <= min_d;
        hour_q       <= hour_d;
        day_q        <= day_d;
        month_q      <= month_d;
        year_q       <= year_d;
        year_lo_q    <= year_lo_d;
        century_q    <= century_d;
        alarm_hour_q <= alarm_hour_d;
        alarm_min_q  <= alarm_min_d;
        alarm_sec_q  <= alarm_sec_d;
        twelve_q     <= twelve_d;
        view_cnt_q   <= view_cnt_d;
        alarm_q      <= alarm_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign mode_state_o        = mode_q;
  assign hours_o             = hour_q;
  assign minutes_o           = min_q;
  assign seconds_o           = sec_q;
  assign day_of_month_o      = day_q;
  assign month_number_o      = month_q;
  assign year_number_o       = year_q;
  assign alarm_hours_o       = alarm_hour_q;
  assign alarm_minutes_o     = alarm_min_q;
  assign alarm_seconds_o     = alarm_sec_q;
  assign alarm_active_o      = alarm_q;
  assign twelve_hour_limit_o = twelve_q;

endmodule

[src/calendar_clock_with_alarm_core_checker.sv]
// ----------------------------------------------------------------------------
// Calendar clock checker
// Port-level assertions on beat flow and result ranges of the core.
// ----------------------------------------------------------------------------
`include "calendar_clock_with_alarm_core_macros.svh"

module calendar_clock_with_alarm_core_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic [ccwa_pkg::ModeW-1:0]      mode_state_o,
  input  logic [ccwa_pkg::HourW-1:0]      hours_o,
  input  logic [ccwa_pkg::MinW-1:0]       minutes_o,
  input  logic [ccwa_pkg::SecW-1:0]       seconds_o
);
  import ccwa_pkg::*;

  // A stalled result beat stays offered.
  `CCWA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // Every accepted input beat yields a result beat in the next cycle.
  `CCWA_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)

  // Input is stalled only while a result beat is held back.
  `CCWA_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // Time fields and mode code stay within their ranges.
  `CCWA_ASSERT_NOW(a_time_range, clk_i, rst_ni, out_valid_o,
                   (int'(seconds_o) < SecCount) && (int'(minutes_o) < MinCount) &&
                   (int'(hours_o) < HourCount) && (mode_state_o <= ModeLast))

endmodule

bind calendar_clock_with_alarm_core calendar_clock_with_alarm_core_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .mode_state_o (mode_state_o),
  .hours_o      (hours_o),
  .minutes_o    (minutes_o),
  .seconds_o    (seconds_o)
);

[tb/sv/clock_calendar_monitor.sv]
// ----------------------------------------------------------------------------
// Calendar clock monitor
// Watches the configuration port and both beat channels of the calendar
// clock core. Every accepted input beat runs through a local model of the
// clock, the calendar, the alarm and the mode machine. The model's view is
// queued and compared, field by field, with the next result beat.
// ----------------------------------------------------------------------------
module clock_calendar_monitor
  import ccwa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              steps_we_i,
  input  logic [StepsW-1:0] steps_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              second_tick_i,
  input  logic              button_mode_i,
  input  logic              button_select_i,
  input  logic              button_adjust_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [ModeW-1:0]  mode_state_i,
  input  logic [HourW-1:0]  hours_i,
  input  logic [MinW-1:0]   minutes_i,
  input  logic [SecW-1:0]   seconds_i,
  input  logic [DayW-1:0]   day_of_month_i,
  input  logic [MonthW-1:0] month_number_i,
  input  logic [YearW-1:0]  year_number_i,
  input  logic [HourW-1:0]  alarm_hours_i,
  input  logic [MinW-1:0]   alarm_minutes_i,
  input  logic [SecW-1:0]   alarm_seconds_i,
  input  logic              alarm_active_i,
  input  logic              twelve_hour_limit_i,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);

  localparam logic [ModeW-1:0] ModeInit      = ModeW'(0);
  localparam logic [ModeW-1:0] ModeTime      = ModeW'(1);
  localparam logic [ModeW-1:0] ModeDateTimed = ModeW'(2);
  localparam logic [ModeW-1:0] ModeDate      = ModeW'(3);
  localparam logic [ModeW-1:0] ModeHourFmt   = ModeW'(4);
  localparam logic [ModeW-1:0] ModeAlarmView = ModeW'(5);
  localparam logic [ModeW-1:0] ModeAlarmHour = ModeW'(6);
  localparam logic [ModeW-1:0] ModeAlarmMin  = ModeW'(7);
  localparam logic [ModeW-1:0] ModeAlarmSec  = ModeW'(8);
  localparam logic [ModeW-1:0] ModeZone      = ModeW'(9);
  localparam logic [ModeW-1:0] ModeInc       = ModeW'(10);
  localparam logic [ModeW-1:0] ModeDec       = ModeW'(11);

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [HourW-1:0]  alarm_hour;
    logic [MinW-1:0]   alarm_minute;
    logic [SecW-1:0]   alarm_second;
    logic              alarm_on;
    logic              limit12;
  } clock_view_t;

  clock_view_t expected_views[$];
  clock_view_t want_view;
  clock_view_t seen_view;

  logic [ModeW-1:0]  mode_q;
  logic [SecW-1:0]   sec_q;
  logic [MinW-1:0]   min_q;
  logic [HourW-1:0]  hour_q;
  logic [DayW-1:0]   day_q;
  logic [MonthW-1:0] month_q;
  logic [YearW-1:0]  year_q;
  logic [HourW-1:0]  alarm_hour_q;
  logic [MinW-1:0]   alarm_min_q;
  logic [SecW-1:0]   alarm_sec_q;
  logic [HourW-1:0]  hour_lim_q;
  logic [StepsW-1:0] view_cnt_q;
  logic [StepsW-1:0] view_len_q;
  logic              alarm_q;

  function automatic void bump_hour();
    if (hour_q + 1 >= hour_lim_q) hour_q = '0;
    else hour_q = hour_q + 1'b1;
  endfunction

  function automatic void drop_hour();
    if (hour_q == '0) hour_q = hour_lim_q - 1'b1;
    else hour_q = hour_q - 1'b1;
  endfunction

  function automatic clock_view_t predict_beat(logic tick, logic bm, logic bs, logic ba);
    int unsigned s, m, h, d, mo, y;
    bit          leap;
    if (tick) begin
      s  = sec_q + 1;
      m  = min_q;
      h  = hour_q;
      d  = day_q;
      mo = month_q;
      y  = year_q;
      if (s >= SecCount) begin
        s = 0;
        m++;
      end
      if (m >= MinCount) begin
        m = 0;
        h++;
      end
      if (h >= HourCount) begin
        h = 0;
        d++;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        if (d > DayLast31) begin
          d = DayFirst;
          mo++;
          if (mo > MonthDec) begin
            mo = MonthJan;
            y = (y >= YearLast) ? 0 : y + 1;
          end
        end else if ((mo == MonthApr || mo == MonthJun || mo == MonthSep ||
                      mo == MonthNov) && d > DayLast30) begin
          d = DayFirst;
          mo++;
        end else if (mo == MonthFeb && d > (leap ? DayLastLeap : DayLastFeb)) begin
          d = DayFirst;
          mo++;
        end
      end
      sec_q   = SecW'(s);
      min_q   = MinW'(m);
      hour_q  = HourW'(h);
      day_q   = DayW'(d);
      month_q = MonthW'(mo);
      year_q  = YearW'(y);
      if (hour_q == alarm_hour_q && min_q == alarm_min_q && sec_q == alarm_sec_q) begin
        alarm_q = 1'b1;
      end
    end
    if (ba) alarm_q = 1'b0;

    case (mode_q)
      ModeInit: mode_q = ModeTime;
      ModeTime: begin
        if (bm) mode_q = ModeDate;
        if (bs) mode_q = ModeDateTimed;
      end
      ModeDateTimed: begin
        if (bm) mode_q = ModeDate;
        view_cnt_q = view_cnt_q + 1'b1;
        if (view_cnt_q >= view_len_q) begin
          view_cnt_q = '0;
          mode_q = ModeTime;
        end
      end
      ModeDate: begin
        if (bm) mode_q = ModeHourFmt;
      end
      ModeHourFmt: begin
        if (bm) mode_q = ModeAlarmView;
        if (bs) hour_lim_q = HourLimit24;
        if (ba) hour_lim_q = HourLimit12;
      end
      ModeAlarmView: begin
        if (bm) mode_q = ModeZone;
        if (bs) mode_q = ModeAlarmHour;
      end
      ModeAlarmHour: begin
        if (bs) mode_q = ModeAlarmMin;
        if (ba) begin
          if (alarm_hour_q + 1 >= hour_lim_q) alarm_hour_q = '0;
          else alarm_hour_q = alarm_hour_q + 1'b1;
        end
        if (bm) mode_q = ModeZone;
      end
      ModeAlarmMin: begin
        if (bs) mode_q = ModeAlarmSec;
        if (ba) begin
          if (alarm_min_q + 1 >= MinCount) alarm_min_q = '0;
          else alarm_min_q = alarm_min_q + 1'b1;
        end
        if (bm) mode_q = ModeZone;
      end
      ModeAlarmSec: begin
        if (bs) mode_q = ModeAlarmHour;
        if (ba) begin
          if (alarm_sec_q + 1 >= SecCount) alarm_sec_q = '0;
          else alarm_sec_q = alarm_sec_q + 1'b1;
        end
        if (bm) mode_q = ModeZone;
      end
      ModeZone: begin
        if (bm) mode_q = ModeTime;
        if (bs) mode_q = ModeInc;
      end
      ModeInc: begin
        if (bm) mode_q = ModeTime;
        if (bs) bump_hour();
        if (ba) begin
          mode_q = ModeDec;
          drop_hour();
        end
      end
      ModeDec: begin
        if (bm) mode_q = ModeTime;
        if (bs) begin
          mode_q = ModeInc;
          bump_hour();
        end
        if (ba) drop_hour();
      end
      default: begin
      end
    endcase

    return '{mode_q, hour_q, min_q, sec_q, day_q, month_q, year_q, alarm_hour_q,
             alarm_min_q, alarm_sec_q, alarm_q, hour_lim_q == HourLimit12};
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (fail_count_o < 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       = ModeInit;
      sec_q        = '0;
      min_q        = '0;
      hour_q       = '0;
      day_q        = DayFirst;
      month_q      = MonthJan;
      year_q       = YearReset;
      alarm_hour_q = '0;
      alarm_min_q  = '0;
      alarm_sec_q  = '0;
      hour_lim_q   = HourLimit24;
      view_cnt_q   = '0;
      view_len_q   = StepsReset;
      alarm_q      = 1'b0;
      expected_views.delete();
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen_view = '{mode_state_i, hours_i, minutes_i, seconds_i, day_of_month_i,
                      month_number_i, year_number_i, alarm_hours_i, alarm_minutes_i,
                      alarm_seconds_i, alarm_active_i, twelve_hour_limit_i};
        if (expected_views.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: result beat arrived with nothing expected", $time);
          end
          fail_count_o++;
        end else begin
          want_view = expected_views.pop_front();
          check_field("mode_state", want_view.mode, seen_view.mode);
          check_field("hours", want_view.hour, seen_view.hour);
          check_field("minutes", want_view.minute, seen_view.minute);
          check_field("seconds", want_view.second, seen_view.second);
          check_field("day_of_month", want_view.day, seen_view.day);
          check_field("month_number", want_view.month, seen_view.month);
          check_field("year_number", want_view.year, seen_view.year);
          check_field("alarm_hours", want_view.alarm_hour, seen_view.alarm_hour);
          check_field("alarm_minutes", want_view.alarm_minute, seen_view.alarm_minute);
          check_field("alarm_seconds", want_view.alarm_second, seen_view.alarm_second);
          check_field("alarm_active", want_view.alarm_on, seen_view.alarm_on);
          check_field("twelve_hour_limit", want_view.limit12, seen_view.limit12);
        end
      end
      if (steps_we_i) view_len_q = steps_i;
      if (in_valid_i && !in_stall_i) begin
        expected_views.push_back(predict_beat(second_tick_i, button_mode_i,
                                              button_select_i, button_adjust_i));
      end
      pending_o = expected_views.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Calendar clock testbench top
// Drives the calendar clock core through a few minute rollovers, a short
// fixed run of mixed mode and button combinations, and random button sessions
// under several date view lengths, with idle gaps and output stalls. The
// monitor and the bound checker do all checking; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ccwa_pkg::*;

  localparam logic [3:0] NoPress     = 4'b0000;
  localparam logic [3:0] StepTick    = 4'b1000;
  localparam logic [3:0] PressMode   = 4'b0100;
  localparam logic [3:0] PressSelect = 4'b0010;
  localparam logic [3:0] PressAdjust = 4'b0001;

  localparam int unsigned CalendarTicks = 150;

  localparam logic [3:0] CalendarSetup [7] = '{
    NoPress, PressMode, PressMode, PressMode, PressMode, PressSelect, PressAdjust
  };

  localparam logic [3:0] OpeningSteps [25] = '{
    PressMode, PressSelect, StepTick | PressSelect, PressMode, PressMode,
    PressAdjust, PressSelect, PressSelect | PressAdjust, StepTick | PressMode,
    PressSelect, PressAdjust, PressSelect | PressAdjust, PressAdjust, PressSelect,
    PressAdjust, PressMode | PressSelect | PressAdjust, PressSelect, PressSelect,
    PressSelect | PressAdjust, PressAdjust, PressSelect, PressAdjust,
    StepTick | PressMode | PressSelect | PressAdjust, PressMode,
    PressMode | PressSelect
  };

  typedef enum int unsigned {StallNone, StallLight, StallHeavy, StallPeriodic} stall_style_e;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              steps_we = 1'b0;
  logic [StepsW-1:0] steps_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              tick = 1'b0;
  logic              bm = 1'b0;
  logic              bs = 1'b0;
  logic              ba = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ModeW-1:0]  mode_state;
  logic [HourW-1:0]  hours;
  logic [MinW-1:0]   minutes;
  logic [SecW-1:0]   seconds;
  logic [DayW-1:0]   day_of_month;
  logic [MonthW-1:0] month_number;
  logic [YearW-1:0]  year_number;
  logic [HourW-1:0]  alarm_hours;
  logic [MinW-1:0]   alarm_minutes;
  logic [SecW-1:0]   alarm_seconds;
  logic              alarm_active;
  logic              twelve_hour_limit;
  int unsigned       pending;
  int unsigned       fails;

  bit                gaps_on = 1'b0;
  int unsigned       burst_left = 0;
  stall_style_e      stall_style = StallNone;
  int unsigned       stall_left = 0;
  int unsigned       stall_phase = 0;

  always #5 clk = ~clk;

  calendar_clock_with_alarm_core dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .date_view_steps_we_i (steps_we),
    .date_view_steps_i    (steps_wdata),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .second_tick_i        (tick),
    .button_mode_i        (bm),
    .button_select_i      (bs),
    .button_adjust_i      (ba),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .mode_state_o         (mode_state),
    .hours_o              (hours),
    .minutes_o            (minutes),
    .seconds_o            (seconds),
    .day_of_month_o       (day_of_month),
    .month_number_o       (month_number),
    .year_number_o        (year_number),
    .alarm_hours_o        (alarm_hours),
    .alarm_minutes_o      (alarm_minutes),
    .alarm_seconds_o      (alarm_seconds),
    .alarm_active_o       (alarm_active),
    .twelve_hour_limit_o  (twelve_hour_limit)
  );

  clock_calendar_monitor monitor (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .steps_we_i          (steps_we),
    .steps_i             (steps_wdata),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .second_tick_i       (tick),
    .button_mode_i       (bm),
    .button_select_i     (bs),
    .button_adjust_i     (ba),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .mode_state_i        (mode_state),
    .hours_i             (hours),
    .minutes_i           (minutes),
    .seconds_i           (seconds),
    .day_of_month_i      (day_of_month),
    .month_number_i      (month_number),
    .year_number_i       (year_number),
    .alarm_hours_i       (alarm_hours),
    .alarm_minutes_i     (alarm_minutes),
    .alarm_seconds_i     (alarm_seconds),
    .alarm_active_i      (alarm_active),
    .twelve_hour_limit_i (twelve_hour_limit),
    .pending_o           (pending),
    .fail_count_o        (fails)
  );

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      stall_left  = $urandom_range(16, 256);
    end
    stall_left--;
    stall_phase++;
    case (stall_style)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 1) == 0);
      default:    out_stall <= (stall_phase % 7 < 3);
    endcase
  end

  function automatic logic one_in(int unsigned n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  task automatic send_step(input logic [3:0] code);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      in_valid <= 1'b0;
      {tick, bm, bs, ba} <= 4'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    {tick, bm, bs, ba} <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic set_view_len(input logic [StepsW-1:0] steps);
    drain_results();
    steps_we    <= 1'b1;
    steps_wdata <= steps;
    @(negedge clk);
    steps_we <= 1'b0;
  endtask

  task automatic press_random_buttons(input int unsigned beats, input int unsigned quiet_max);
    int unsigned done_beats;
    int unsigned run_len;
    int unsigned roll;
    logic [3:0]  code;
    done_beats = 0;
    while (done_beats < beats) begin
      roll = $urandom_range(0, 9);
      if (roll < 5) run_len = $urandom_range(4, 30);
      else if (roll < 8) run_len = $urandom_range(10, quiet_max);
      else if (roll == 8) run_len = $urandom_range(3, 12);
      else run_len = $urandom_range(20, 120);
      repeat (run_len) begin
        if (roll < 5) code = {one_in(2), one_in(4), one_in(4), one_in(4)};
        else if (roll < 8) code = {one_in(2), 1'b0, one_in(6), one_in(6)};
        else if (roll == 8) code = {one_in(2), 1'b1, 1'b0, 1'b0};
        else code = StepTick;
        send_step(code);
      end
      done_beats += run_len;
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk to the hour-down mode so the clock sits at 23:00:00, then tick the
    // seconds through a few minute rollovers.
    foreach (CalendarSetup[k]) send_step(CalendarSetup[k]);
    repeat (CalendarTicks) send_step(StepTick);

    gaps_on = 1'b1;
    foreach (OpeningSteps[k]) send_step(OpeningSteps[k]);

    set_view_len(StepsW'(1023));
    press_random_buttons(750, 400);
    set_view_len(StepsW'(0));
    press_random_buttons(170, 60);
    set_view_len(StepsW'(1));
    press_random_buttons(170, 60);
    set_view_len(StepsW'($urandom_range(2, 40)));
    press_random_buttons(210, 60);
    set_view_len(StepsReset);
    press_random_buttons(120, 60);
    set_view_len(StepsW'($urandom_range(2, 40)));
    press_random_buttons(170, 60);

    drain_results();
    repeat (4) @(negedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
